[rtl/core/rsds_pkg.sv]
// ----------------------------------------------------------------------------
// rsds_pkg: shared types and constants
// Action and status codes and the queue entry between front and back.
// ----------------------------------------------------------------------------
package rsds_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int KEY_W         = 16;
   localparam int PAY_W         = 32;
   localparam int COUNT_W       = 5;

   typedef enum logic [2:0] {
      ACT_PUSH   = 3'd0,
      ACT_POP    = 3'd1,
      ACT_PEEK   = 3'd2,
      ACT_DELETE = 3'd3,
      ACT_SORT   = 3'd4,
      ACT_NOP    = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      action_type       action;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEL_RD,
      S_SORT_OUTER,
      S_SORT_RD,
      S_SORT_CMP,
      S_SORT_PLACE,
      S_PEEK_RD,
      S_DONE
   } state_type;

endpackage

[rtl/core/record_stack_delete_sort.sv]
// ----------------------------------------------------------------------------
// record_stack_delete_sort: keyed record stack
// Bounded stack with push, pop, peek, delete by key and stable key sort.
// ----------------------------------------------------------------------------
// One request at a time is carried out by the stack engine over its single
// entry memory (one write, one registered read per cycle). Push writes the
// top slot, pop and peek read the top entry, delete compacts survivors over
// all entries, and sort is an insertion sort. A two-entry request queue keeps
// intake going while the engine works, and the result register holds the
// response until it is taken. No clearing pass after reset.
module record_stack_delete_sort #(
   parameter int STACK_DEPTH = rsds_pkg::DEFAULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // action[2:0], item_key[18:3], item_payload[50:19]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // status[1:0], out_key[17:2], out_payload[49:18],
                                   // entry_count[54:50]
);
   import rsds_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   rsds_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .cmd_valid, .cmd_ready, .cmd
   );

   rsds_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule

[rtl/core/rsds_front.sv]
// ----------------------------------------------------------------------------
// rsds_front: request intake
// Accepts requests, folds unused action codes into a no-op, and queues them.
// ----------------------------------------------------------------------------
module rsds_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [55:0]       req_tdata,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output rsds_pkg::cmd_type cmd
);
   import rsds_pkg::*;

   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   cmd_type    c;
   logic       push, pop;

   always_comb begin
      c.key     = req_tdata[18:3];
      c.payload = req_tdata[50:19];
      if (req_tdata[2:0] inside {3'd0, 3'd1, 3'd2, 3'd3, 3'd4}) begin
         c.action = action_type'(req_tdata[2:0]);
      end else begin
         c.action = ACT_NOP;
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[rd_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign wr_in      = wr_ff ^ push;
   assign rd_in      = rd_ff ^ pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= c;
      end
   end

endmodule

[rtl/core/rsds_back.sv]
// ----------------------------------------------------------------------------
// rsds_back: stack engine
// Runs one command at a time against the entry memory and registers result.
// ----------------------------------------------------------------------------
module rsds_back #(
   parameter int STACK_DEPTH = rsds_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  rsds_pkg::cmd_type cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [55:0]       rsp_tdata
);
   import rsds_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int LW = $clog2(STACK_DEPTH + 1);

   logic [KEY_W+PAY_W-1:0] mem [STACK_DEPTH];
   logic [KEY_W+PAY_W-1:0] rdata_ff;

   state_type      state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [LW-1:0]  lvl_ff, lvl_in;
   logic [LW-1:0]  i_ff, i_in, j_ff, j_in, wr_ff, wr_in;
   logic           found_ff, found_in;
   logic [KEY_W+PAY_W-1:0] hold_ff, hold_in;
   logic           ovalid_ff, ovalid_in;
   logic [55:0]    odata_ff, odata_in;
   logic           we;
   logic [AW-1:0]  waddr, raddr;
   logic [KEY_W+PAY_W-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   function automatic logic [55:0] pack(status_type s, logic [KEY_W+PAY_W-1:0] e,
                                        logic [LW-1:0] n);
      logic [COUNT_W+LW-1:0] nn;
      nn = {{COUNT_W{1'b0}}, n};
      return {1'b0, nn[COUNT_W-1:0], e[PAY_W-1:0], e[KEY_W+PAY_W-1:PAY_W], s};
   endfunction

   assign cmd_ready  = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      lvl_in    = lvl_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      wr_in     = wr_ff;
      found_in  = found_ff;
      hold_in   = hold_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      we        = 1'b0;
      waddr     = '0;
      wdata     = '0;
      raddr     = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cmd_in = cmd;
               i_in   = '0;
               wr_in  = '0;
               found_in = 1'b0;
               case (cmd.action)
                  ACT_PUSH: begin
                     if (lvl_ff == LW'(STACK_DEPTH)) begin
                        odata_in = pack(ST_FULL, '0, lvl_ff);
                     end else begin
                        we     = 1'b1;
                        waddr  = lvl_ff[AW-1:0];
                        wdata  = {cmd.key, cmd.payload};
                        lvl_in = lvl_ff + 1'b1;
                        odata_in = pack(ST_OK, '0, lvl_in);
                     end
                     ovalid_in = 1'b1;
                  end
                  ACT_POP, ACT_PEEK: begin
                     if (lvl_ff == '0) begin
                        odata_in  = pack(ST_EMPTY, '0, lvl_ff);
                        ovalid_in = 1'b1;
                     end else begin
                        raddr    = AW'(lvl_ff - 1'b1);
                        state_in = S_PEEK_RD;
                     end
                  end
                  ACT_DELETE: begin
                     raddr    = '0;
                     state_in = S_DEL_RD;
                  end
                  ACT_SORT: begin
                     i_in     = LW'(1);
                     state_in = S_SORT_OUTER;
                  end
                  default: begin
                     odata_in  = pack(ST_OK, '0, lvl_ff);
                     ovalid_in = 1'b1;
                  end
               endcase
            end
         end
         S_PEEK_RD: begin
            if (cmd_ff.action == ACT_POP) begin
               lvl_in = lvl_ff - 1'b1;
            end
            odata_in  = pack(ST_OK, rdata_ff, lvl_in);
            ovalid_in = 1'b1;
            state_in  = S_IDLE;
         end
         // rdata_ff holds entry i; compact survivors down to wr
         S_DEL_RD: begin
            if (i_ff == lvl_ff) begin
               lvl_in    = wr_ff;
               odata_in  = pack(found_ff ? ST_OK : ST_NOTFOUND, '0, wr_ff);
               ovalid_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               if (rdata_ff[KEY_W+PAY_W-1:PAY_W] == cmd_ff.key) begin
                  found_in = 1'b1;
               end else begin
                  we    = 1'b1;
                  waddr = wr_ff[AW-1:0];
                  wdata = rdata_ff;
                  wr_in = wr_ff + 1'b1;
               end
               i_in  = i_ff + 1'b1;
               raddr = AW'(i_ff + 1'b1);
            end
         end
         S_SORT_OUTER: begin
            if (i_ff >= lvl_ff) begin
               odata_in  = pack(ST_OK, '0, lvl_ff);
               ovalid_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               raddr    = i_ff[AW-1:0];
               j_in     = i_ff;
               state_in = S_SORT_RD;
            end
         end
         S_SORT_RD: begin
            hold_in  = rdata_ff;
            raddr    = AW'(j_ff - 1'b1);
            state_in = S_SORT_CMP;
         end
         // rdata_ff holds entry j-1
         S_SORT_CMP: begin
            if (rdata_ff[KEY_W+PAY_W-1:PAY_W] < hold_ff[KEY_W+PAY_W-1:PAY_W]) begin
               we    = 1'b1;
               waddr = j_ff[AW-1:0];
               wdata = rdata_ff;
               j_in  = j_ff - 1'b1;
               if (j_ff == LW'(1)) begin
                  state_in = S_SORT_PLACE;
               end else begin
                  raddr = AW'(j_ff - LW'(2));
               end
            end else begin
               state_in = S_SORT_PLACE;
            end
         end
         S_SORT_PLACE: begin
            we       = 1'b1;
            waddr    = j_ff[AW-1:0];
            wdata    = hold_ff;
            i_in     = i_ff + 1'b1;
            state_in = S_SORT_OUTER;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         lvl_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         lvl_ff    <= lvl_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      wr_ff    <= wr_in;
      found_ff <= found_in;
      hold_ff  <= hold_in;
      odata_ff <= odata_in;
   end

endmodule

[test/record_stack_delete_sort_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_stack_delete_sort_test: self-checking bench for the keyed record stack
// Directed table of requests, then random push/pop/peek/delete/sort traffic,
// every response compared with a typed value or a behavioral stack model of depth 16.
// ----------------------------------------------------------------------------
module record_stack_delete_sort_test;
   import rsds_pkg::*;

   localparam int DEPTH       = 16;
   localparam int N_RANDOM    = 1900;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic [1:0]       status;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      logic [4:0]       count;
   } resp_type;

   typedef struct {
      logic [2:0]       action;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      bit               typed;
      resp_type         resp;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   // stack model
   logic [KEY_W-1:0] stack_keys [DEPTH];
   logic [PAY_W-1:0] stack_pays [DEPTH];
   int               stack_fill;

   resp_type expected_responses [$];
   int       mismatches;
   int       cycles;
   bit       calm;          // no idling near the end
   bit       long_hold;

   record_stack_delete_sort DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic resp_type apply_request(logic [2:0] act, logic [KEY_W-1:0] k,
                                              logic [PAY_W-1:0] p);
      resp_type         r;
      int               wr;
      bit               found;
      logic [KEY_W-1:0] hk;
      logic [PAY_W-1:0] hp;
      int               j;
      r = '0;
      r.status = ST_OK;
      case (act)
         ACT_PUSH: begin
            if (stack_fill >= DEPTH) r.status = ST_FULL;
            else begin
               stack_keys[stack_fill] = k;
               stack_pays[stack_fill] = p;
               stack_fill++;
            end
         end
         ACT_POP, ACT_PEEK: begin
            if (stack_fill == 0) r.status = ST_EMPTY;
            else begin
               r.key = stack_keys[stack_fill-1];
               r.payload = stack_pays[stack_fill-1];
               if (act == ACT_POP) stack_fill--;
            end
         end
         ACT_DELETE: begin
            wr = 0;
            found = 0;
            for (int rd = 0; rd < stack_fill; rd++) begin
               if (stack_keys[rd] == k) found = 1;
               else begin
                  stack_keys[wr] = stack_keys[rd];
                  stack_pays[wr] = stack_pays[rd];
                  wr++;
               end
            end
            stack_fill = wr;
            r.status = found ? ST_OK : ST_NOTFOUND;
         end
         ACT_SORT: begin
            // stable, keys descending bottom to top
            for (int i = 1; i < stack_fill; i++) begin
               hk = stack_keys[i];
               hp = stack_pays[i];
               j = i;
               while (j > 0 && stack_keys[j-1] < hk) begin
                  stack_keys[j] = stack_keys[j-1];
                  stack_pays[j] = stack_pays[j-1];
                  j--;
               end
               stack_keys[j] = hk;
               stack_pays[j] = hp;
            end
         end
         default: ;
      endcase
      r.count = stack_fill[4:0];
      return r;
   endfunction

   task automatic send_request(logic [2:0] act, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                               bit typed, resp_type typed_resp);
      resp_type r;
      int       gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, p, k, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = apply_request(act, k, p);
      expected_responses.push_back(typed ? typed_resp : r);
   endtask

   function automatic resp_type mk(logic [1:0] s, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                                   logic [4:0] c);
      resp_type r;
      r.status = s; r.key = k; r.payload = p; r.count = c;
      return r;
   endfunction

   // response checking
   always @(posedge clock) begin
      resp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[1:0], rsp_tdata[17:2], rsp_tdata[49:18], rsp_tdata[54:50]};
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = expected_responses.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: status %0d/%0d key %h/%h payload %h/%h count %0d/%0d",
                           want.status, got.status, want.key, got.key,
                           want.payload, got.payload, want.count, got.count);
            end
         end
      end
   end

   // receiver side: random stalls, one long hold
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      row_type          rows [$];
      logic [2:0]       act;
      logic [KEY_W-1:0] k;
      int               sel;
      int               wait_cycles;
      mismatches = 0;
      stack_fill = 0;
      calm = 0;
      long_hold = 0;
      // directed rows: typed responses where obvious
      rows.push_back('{ACT_POP,    16'h0000, 32'h0, 1, mk(ST_EMPTY, 0, 0, 0)});
      rows.push_back('{ACT_PEEK,   16'hFFFF, 32'hFFFFFFFF, 1, mk(ST_EMPTY, 0, 0, 0)});
      rows.push_back('{ACT_DELETE, 16'h1234, 32'h0, 1, mk(ST_NOTFOUND, 0, 0, 0)});
      rows.push_back('{ACT_SORT,   16'h0, 32'h0, 1, mk(ST_OK, 0, 0, 0)});
      rows.push_back('{3'd5,       16'hFFFF, 32'hFFFFFFFF, 1, mk(ST_OK, 0, 0, 0)});
      rows.push_back('{3'd7,       16'h0, 32'h0, 1, mk(ST_OK, 0, 0, 0)});
      rows.push_back('{ACT_PUSH,   16'hFFFF, 32'hFFFFFFFF, 1, mk(ST_OK, 0, 0, 1)});
      rows.push_back('{ACT_PEEK,   16'h0, 32'h0, 1, mk(ST_OK, 16'hFFFF, 32'hFFFFFFFF, 1)});
      rows.push_back('{ACT_PUSH,   16'h0000, 32'h00000000, 1, mk(ST_OK, 0, 0, 2)});
      rows.push_back('{ACT_PUSH,   16'h0005, 32'hA5A5A5A5, 0, '0});
      rows.push_back('{ACT_PUSH,   16'h0005, 32'h5A5A5A5A, 0, '0});
      rows.push_back('{ACT_SORT,   16'h0, 32'h0, 0, '0});
      rows.push_back('{ACT_POP,    16'h0, 32'h0, 0, '0});
      rows.push_back('{ACT_DELETE, 16'h0005, 32'h0, 0, '0});
      for (int i = 0; i < 16; i++)
         rows.push_back('{ACT_PUSH, 16'(i * 4099), 32'(i * 32'h11111111), 0, '0});
      rows.push_back('{ACT_PUSH, 16'hBEEF, 32'hDEADBEEF, 1, mk(ST_FULL, 0, 0, 16)});
      rows.push_back('{ACT_SORT, 16'h0, 32'h0, 0, '0});
      rows.push_back('{ACT_POP,  16'h0, 32'h0, 0, '0});
      rows.push_back('{ACT_DELETE, 16'hFFFF, 32'h0, 0, '0});
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_request(rows[i].action, rows[i].key, rows[i].payload,
                                      rows[i].typed, rows[i].resp);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 300) long_hold = 1;
         if (n == 700) begin
            // pause until everything has drained
            req_tvalid <= 1'b0;
            while (expected_responses.size() != 0) @(posedge clock);
         end
         if (n == N_RANDOM - 200) calm = 1;
         sel = $urandom_range(0, 99);
         // keys from a small pool mostly so deletes and sort ties hit
         k = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
         if (sel < 40) act = ACT_PUSH;
         else if (sel < 60) act = ACT_POP;
         else if (sel < 72) act = ACT_PEEK;
         else if (sel < 86) act = ACT_DELETE;
         else if (sel < 96) act = ACT_SORT;
         else act = 3'($urandom_range(5, 7));
         send_request(act, k, $urandom, 0, '0);
      end
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (expected_responses.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (600) @(posedge clock);
      if (mismatches == 0 && expected_responses.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/rsds_pkg.sv
rtl/core/rsds_front.sv
rtl/core/rsds_back.sv
rtl/core/record_stack_delete_sort.sv
test/record_stack_delete_sort_test.sv
